// ===== rtl/quintic_joint_trajectory_macros.svh =====
// Assertion macros of the trajectory generator RTL.
`ifndef QUINTIC_JOINT_TRAJECTORY_MACROS_SVH
`define QUINTIC_JOINT_TRAJECTORY_MACROS_SVH
// Checks a property on every clock edge outside reset.
`define QJT_ASSERT(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
// Checks a property on every clock edge, reset included.
`define QJT_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);
`endif

// ===== rtl/qjt_pkg.sv =====
// Package with payload types, phase codes and constants of the trajectory generator.
package qjt_pkg;

    localparam int NJ = 3;

    typedef enum logic [1:0] {
        PHASE_IDLE    = 2'd0,
        PHASE_STARTED = 2'd1,
        PHASE_MOVING  = 2'd2,
        PHASE_ARRIVED = 2'd3
    } phase_t;

    typedef enum logic [1:0] {
        CFG_MAX_SPEED    = 2'd0,
        CFG_MIN_DURATION = 2'd1,
        CFG_SAMPLE_TIME  = 2'd2,
        CFG_RELATIVE     = 2'd3
    } cfg_index_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SDIV,
        ST_DIVW,
        ST_POW,
        ST_POLY,
        ST_LERP,
        ST_LERPW,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic               kind;
        logic signed [31:0] start_joint0;
        logic signed [31:0] start_joint1;
        logic signed [31:0] start_joint2;
        logic signed [31:0] target_joint0;
        logic signed [31:0] target_joint1;
        logic signed [31:0] target_joint2;
    } in_word_t;

    typedef struct packed {
        logic signed [31:0] pos_joint0;
        logic signed [31:0] pos_joint1;
        logic signed [31:0] pos_joint2;
        logic [1:0]         phase;
        logic [31:0]        move_time;
    } out_word_t;

    // Control from the sequencer to the lanes.
    typedef struct packed {
        logic div_start;
        logic lerp_start;
    } lane_ctl_t;

endpackage

// ===== rtl/qjt_divider.sv =====
// Restoring divider that produces one quotient bit per cycle.
module qjt_divider #(
    parameter int NW = 48,
    parameter int DW = 32
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          start,
    input  logic [NW-1:0] numer,
    input  logic [DW-1:0] denom,
    output logic          busy,
    output logic [NW-1:0] quot
);

    localparam int CW = $clog2(NW + 1);

    logic [NW-1:0] q_reg, q_next;
    logic [DW:0]   rem_reg, rem_next;
    logic [DW-1:0] d_reg, d_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          busy_reg, busy_next;
    logic [DW:0]   trial;

    always_comb begin
        q_next = q_reg;
        rem_next = rem_reg;
        d_next = d_reg;
        cnt_next = cnt_reg;
        busy_next = busy_reg;
        trial = {rem_reg[DW-1:0], q_reg[NW-1]};
        if (start) begin
            q_next = numer;
            rem_next = '0;
            d_next = denom;
            cnt_next = CW'(NW);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (trial >= {1'b0, d_reg}) begin
                rem_next = trial - {1'b0, d_reg};
                q_next = {q_reg[NW-2:0], 1'b1};
            end else begin
                rem_next = trial;
                q_next = {q_reg[NW-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1)) begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg <= '0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg <= cnt_next;
        end
        q_reg <= q_next;
        rem_reg <= rem_next;
        d_reg <= d_next;
    end

    assign busy = busy_reg;
    assign quot = q_reg;

endmodule

// ===== rtl/qjt_lane.sv =====
// One joint lane: goal capture, move-time division and blended position.
module qjt_lane #(
    parameter int FB = 16
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               load,
    input  logic signed [31:0] start_in,
    input  logic signed [31:0] target_in,
    input  logic               relative,
    input  logic [31:0]        speed,
    input  logic [31:0]        min_dur,
    input  qjt_pkg::lane_ctl_t ctl,
    input  logic [FB:0]        r_in,
    output logic               busy,
    output logic [31:0]        move_t,
    output logic signed [31:0] start_q,
    output logic signed [31:0] goal_q,
    output logic signed [31:0] blend
);

    localparam int NW = 32 + FB;

    logic signed [31:0] start_reg, goal_reg;
    logic signed [32:0] sum;
    logic signed [31:0] goal_new;
    logic signed [32:0] dlt;
    logic [31:0]        mag;
    logic [NW-1:0]      numer, quot;
    logic               dbusy;
    logic [NW:0]        tsum;
    logic [32:0]        dmag_reg;
    logic               dneg_reg;
    logic [32+FB:0]     prod_reg;
    logic [32:0]        dmag;
    logic [32+FB-FB:0]  qmag;

    assign sum = 33'(start_in) + 33'(target_in);
    always_comb begin
        if (!relative) begin
            goal_new = target_in;
        end else if (sum > 33'sd2147483647) begin
            goal_new = 32'sh7fffffff;
        end else if (sum < -33'sd2147483648) begin
            goal_new = 32'sh80000000;
        end else begin
            goal_new = sum[31:0];
        end
    end

    assign dlt = 33'(goal_new) - 33'(start_in);
    assign mag = dlt[32] ? 32'(-dlt) : dlt[31:0];
    assign numer = {mag, {FB{1'b0}}};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_reg <= '0;
            goal_reg <= '0;
        end else if (load) begin
            start_reg <= start_in;
            goal_reg <= goal_new;
        end
    end

    qjt_divider #(.NW(NW), .DW(32)) u_div (
        .aclk(aclk), .aresetn(aresetn), .start(ctl.div_start && load),
        .numer(numer), .denom(speed), .busy(dbusy), .quot(quot)
    );

    assign tsum = {1'b0, quot} + (NW + 1)'(min_dur);
    assign move_t = (tsum > (NW + 1)'(32'hffffffff)) ? 32'hffffffff : tsum[31:0];
    assign busy = dbusy;

    // Interpolation: one multiply registered, then scale and sign.
    assign dmag = (33'(goal_reg) - 33'(start_reg));
    always_ff @(posedge aclk) begin
        if (ctl.lerp_start) begin
            dneg_reg <= dmag[32];
            dmag_reg <= dmag[32] ? -dmag : dmag;
        end
        prod_reg <= (33 + FB)'(dmag_reg) * (33 + FB)'(r_in);
    end
    assign qmag = prod_reg[32+FB:FB];
    assign blend = dneg_reg ? 32'(33'(start_reg) - qmag) : 32'(33'(start_reg) + qmag);
    assign start_q = start_reg;
    assign goal_q = goal_reg;

endmodule

// ===== rtl/quintic_joint_trajectory.sv =====
// Top level of the three-joint minimum-jerk trajectory generator.
// Each input word is either a start word, which captures start and goal positions
// per joint and computes the move time as the largest over the joints of
// min_duration + |goal - start| / max_speed (saturated), or a tick word, which
// outputs start + r * (goal - start) with r = 10s^3 - 15s^4 + 6s^5 and s = t / T
// in the moving phase and the goal otherwise, and advances t by sample_time while
// a move is active. One word is worked at a time. A start word waits on the
// bit-serial divider in each joint lane (the lanes divide in parallel). An active
// tick word in the moving phase goes through the shared s = t / T divider, then
// four sequential power products and the lane multiplies; idle and arrived ticks
// go straight to the output state. A result waits in an output register until
// taken, and the next word is accepted in the cycle after it is taken.
module quintic_joint_trajectory #(
    parameter int JOINTS = 3,
    parameter int FRAC_BITS = 16
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  qjt_pkg::in_word_t s_data,
    output logic             m_valid,
    input  logic             m_ready,
    output qjt_pkg::out_word_t m_data,
    input  logic             cfg_we,
    input  logic [1:0]       cfg_index,
    input  logic [31:0]      cfg_data
);

    `include "quintic_joint_trajectory_macros.svh"

    localparam int FB = FRAC_BITS;
    localparam int NW = 32 + FB;

    // Configuration registers.
    logic [31:0] max_speed_reg, min_duration_reg, sample_time_reg;
    logic        relative_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_speed_reg <= 32'd65536;
            min_duration_reg <= 32'd131072;
            sample_time_reg <= 32'd13107;
            relative_reg <= 1'b0;
        end else if (cfg_we) begin
            unique case (qjt_pkg::cfg_index_t'(cfg_index))
                qjt_pkg::CFG_MAX_SPEED:    max_speed_reg <= cfg_data;
                qjt_pkg::CFG_MIN_DURATION: min_duration_reg <= cfg_data;
                qjt_pkg::CFG_SAMPLE_TIME:  sample_time_reg <= cfg_data;
                qjt_pkg::CFG_RELATIVE:     relative_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // Zero speed behaves as the smallest nonzero speed.
    logic [31:0] speed;
    assign speed = (max_speed_reg == '0) ? 32'd1 : max_speed_reg;

    // Move state.
    logic [31:0] elapsed_reg, elapsed_next, duration_reg, duration_next;
    logic        active_reg, active_next;
    qjt_pkg::state_t state_reg, state_next;
    logic        kind_reg, kind_next;
    qjt_pkg::out_word_t out_reg, out_next;
    logic        mvalid_reg, mvalid_next;
    logic [NW-1:0] s_reg, s_next;       // holds s
    logic [FB:0]   sp_reg [4];          // s^3..s^5 in [1..3], latest power in [0]
    logic [2:0]    pcnt_reg, pcnt_next;
    logic [FB:0]   r_reg, r_next;

    logic accept;
    assign s_ready = (state_reg == qjt_pkg::ST_IDLE) && !mvalid_reg;
    assign accept = s_valid && s_ready;

    // Shared s = t / T divider.
    logic          sdiv_start, sdiv_busy;
    logic [NW-1:0] sdiv_q;
    qjt_divider #(.NW(NW), .DW(32)) u_sdiv (
        .aclk(aclk), .aresetn(aresetn), .start(sdiv_start),
        .numer({elapsed_reg, {FB{1'b0}}}), .denom(duration_reg),
        .busy(sdiv_busy), .quot(sdiv_q)
    );

    // Joint lanes, all fed by the same control word.
    qjt_pkg::lane_ctl_t  lctl;
    logic [qjt_pkg::NJ-1:0] lbusy;
    logic [31:0]        lmove [qjt_pkg::NJ];
    logic signed [31:0] lstart [qjt_pkg::NJ];
    logic signed [31:0] lgoal [qjt_pkg::NJ];
    logic signed [31:0] lblend [qjt_pkg::NJ];
    logic signed [31:0] sj [qjt_pkg::NJ];
    logic signed [31:0] tj [qjt_pkg::NJ];

    assign sj[0] = s_data.start_joint0;
    assign sj[1] = s_data.start_joint1;
    assign sj[2] = s_data.start_joint2;
    assign tj[0] = s_data.target_joint0;
    assign tj[1] = s_data.target_joint1;
    assign tj[2] = s_data.target_joint2;

    for (genvar j = 0; j < qjt_pkg::NJ; j++) begin : g_lane
        if (j < JOINTS) begin : g_on
            qjt_lane #(.FB(FB)) u_lane (
                .aclk(aclk), .aresetn(aresetn),
                .load(accept && !s_data.kind),
                .start_in(sj[j]), .target_in(tj[j]), .relative(relative_reg),
                .speed(speed), .min_dur(min_duration_reg), .ctl(lctl),
                .r_in(r_reg), .busy(lbusy[j]), .move_t(lmove[j]),
                .start_q(lstart[j]), .goal_q(lgoal[j]), .blend(lblend[j])
            );
        end else begin : g_off
            assign lbusy[j] = 1'b0;
            assign lmove[j] = '0;
            assign lstart[j] = '0;
            assign lgoal[j] = '0;
            assign lblend[j] = '0;
        end
    end

    // Merge stage: largest move time over the lanes.
    logic [31:0] best;
    always_comb begin
        best = '0;
        for (int j = 0; j < qjt_pkg::NJ; j++) begin
            if (lmove[j] > best) begin
                best = lmove[j];
            end
        end
    end

    // Polynomial: s^3, s^4, s^5 are FB + 1 bits wide, at most 2^FB.
    logic signed [FB+6:0] poly;
    assign poly = (FB + 7)'(10) * $signed({1'b0, sp_reg[1]})
                - (FB + 7)'(15) * $signed({1'b0, sp_reg[2]})
                + (FB + 7)'(6) * $signed({1'b0, sp_reg[3]});

    logic [2*FB+1:0] pprod;
    assign pprod = (2 * FB + 2)'(s_reg[FB:0]) * (2 * FB + 2)'(sp_reg[0]);

    logic [32:0] esum;
    assign esum = {1'b0, elapsed_reg} + {1'b0, sample_time_reg};

    // Next-state logic.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            qjt_pkg::ST_IDLE: begin
                if (accept) begin
                    if (!s_data.kind) begin
                        state_next = qjt_pkg::ST_DIVW;
                    end else if (active_reg && elapsed_reg <= duration_reg) begin
                        state_next = qjt_pkg::ST_SDIV;
                    end else begin
                        state_next = qjt_pkg::ST_OUT;
                    end
                end
            end
            qjt_pkg::ST_SDIV: state_next = qjt_pkg::ST_POW;
            qjt_pkg::ST_DIVW: begin
                if (kind_reg) begin
                    if (!sdiv_busy) state_next = qjt_pkg::ST_POW;
                end else if (lbusy == '0) begin
                    state_next = qjt_pkg::ST_OUT;
                end
            end
            qjt_pkg::ST_POW: begin
                if (sdiv_busy) begin
                    state_next = qjt_pkg::ST_POW;
                end else if (pcnt_reg == 3'd4) begin
                    state_next = qjt_pkg::ST_POLY;
                end
            end
            qjt_pkg::ST_POLY:  state_next = qjt_pkg::ST_LERP;
            qjt_pkg::ST_LERP:  state_next = qjt_pkg::ST_LERPW;
            qjt_pkg::ST_LERPW: state_next = qjt_pkg::ST_OUT;
            qjt_pkg::ST_OUT:   state_next = qjt_pkg::ST_IDLE;
            default:           state_next = qjt_pkg::ST_IDLE;
        endcase
    end

    // Output and datapath logic.
    always_comb begin
        elapsed_next = elapsed_reg;
        duration_next = duration_reg;
        active_next = active_reg;
        kind_next = kind_reg;
        out_next = out_reg;
        mvalid_next = mvalid_reg;
        s_next = s_reg;
        pcnt_next = pcnt_reg;
        r_next = r_reg;
        sdiv_start = 1'b0;
        lctl = '0;
        if (mvalid_reg && m_ready) begin
            mvalid_next = 1'b0;
        end
        unique case (state_reg)
            qjt_pkg::ST_IDLE: begin
                if (accept) begin
                    kind_next = s_data.kind;
                    lctl.div_start = !s_data.kind;
                end
            end
            qjt_pkg::ST_SDIV: begin
                sdiv_start = (duration_reg != '0) && (elapsed_reg < duration_reg);
                pcnt_next = 3'd0;
            end
            qjt_pkg::ST_POW: begin
                if (!sdiv_busy) begin
                    if (pcnt_reg == 3'd0) begin
                        if (duration_reg == '0 || elapsed_reg >= duration_reg) begin
                            s_next = NW'(1) << FB;
                        end else begin
                            s_next = sdiv_q;
                        end
                        pcnt_next = 3'd1;
                    end else begin
                        pcnt_next = pcnt_reg + 3'd1;
                    end
                end
            end
            qjt_pkg::ST_POLY: begin
                if (poly < 0) begin
                    r_next = '0;
                end else if (poly > $signed((FB + 7)'(1) << FB)) begin
                    r_next = (FB + 1)'(1) << FB;
                end else begin
                    r_next = poly[FB:0];
                end
            end
            qjt_pkg::ST_LERP: lctl.lerp_start = 1'b1;
            qjt_pkg::ST_DIVW: begin
                if (!kind_reg && lbusy == '0) begin
                    duration_next = best;
                end
            end
            qjt_pkg::ST_OUT: begin
                mvalid_next = 1'b1;
                out_next.move_time = duration_reg;
                if (!kind_reg) begin
                    out_next.phase = qjt_pkg::PHASE_STARTED;
                    out_next.pos_joint0 = lstart[0];
                    out_next.pos_joint1 = lstart[1];
                    out_next.pos_joint2 = lstart[2];
                    elapsed_next = '0;
                    active_next = 1'b1;
                end else if (!active_reg) begin
                    out_next.phase = qjt_pkg::PHASE_IDLE;
                    out_next.pos_joint0 = lgoal[0];
                    out_next.pos_joint1 = lgoal[1];
                    out_next.pos_joint2 = lgoal[2];
                end else begin
                    if (elapsed_reg <= duration_reg) begin
                        out_next.phase = qjt_pkg::PHASE_MOVING;
                        out_next.pos_joint0 = lblend[0];
                        out_next.pos_joint1 = lblend[1];
                        out_next.pos_joint2 = lblend[2];
                    end else begin
                        out_next.phase = qjt_pkg::PHASE_ARRIVED;
                        out_next.pos_joint0 = lgoal[0];
                        out_next.pos_joint1 = lgoal[1];
                        out_next.pos_joint2 = lgoal[2];
                    end
                    elapsed_next = esum[32] ? 32'hffffffff : esum[31:0];
                end
            end
            default: ;
        endcase
    end

    // Power chain into sp_reg[1..3] = s^3..s^5; the first product squares s.
    always_ff @(posedge aclk) begin
        if (state_reg == qjt_pkg::ST_POW && !sdiv_busy) begin
            if (pcnt_reg == 3'd0) begin
                sp_reg[0] <= '0;
            end else if (pcnt_reg == 3'd1) begin
                sp_reg[0] <= (FB + 1)'((2 * FB + 2)'(s_reg[FB:0]) * (2 * FB + 2)'(s_reg[FB:0])
                             >> FB);
            end else begin
                sp_reg[2'(pcnt_reg - 3'd1)] <= (FB + 1)'(pprod >> FB);
                sp_reg[0] <= (FB + 1)'(pprod >> FB);
            end
        end
        if (state_reg == qjt_pkg::ST_POW && !sdiv_busy && pcnt_reg == 3'd1) begin
            sp_reg[3] <= sp_reg[3];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= qjt_pkg::ST_IDLE;
            elapsed_reg <= '0;
            duration_reg <= '0;
            active_reg <= 1'b0;
            mvalid_reg <= 1'b0;
            kind_reg <= 1'b0;
            pcnt_reg <= '0;
            r_reg <= '0;
        end else begin
            state_reg <= state_next;
            elapsed_reg <= elapsed_next;
            duration_reg <= duration_next;
            active_reg <= active_next;
            mvalid_reg <= mvalid_next;
            kind_reg <= kind_next;
            pcnt_reg <= pcnt_next;
            r_reg <= r_next;
        end
        out_reg <= out_next;
        s_reg <= s_next;
    end

    assign m_valid = mvalid_reg;
    assign m_data = out_reg;

    `QJT_ASSERT(a_out_hold, aclk, aresetn, (m_valid && !m_ready) |=> m_valid, "result dropped")
    `QJT_ASSERT(a_no_accept_busy, aclk, aresetn, m_valid |-> !s_ready, "accepted while result waits")
    `QJT_ASSERT(a_r_range, aclk, aresetn, r_reg <= ((FB + 1)'(1) << FB), "blend factor out of range")
    `QJT_ASSERT(a_start_active, aclk, aresetn, (m_valid && m_data.phase == qjt_pkg::PHASE_STARTED) |-> active_reg, "start without active")

endmodule

// ===== tb/sv/tb_quintic_joint_trajectory.sv =====
// Self-checking testbench of the three-joint minimum-jerk trajectory generator.
`timescale 1ns / 100ps

module tb_quintic_joint_trajectory;

    // The watchdog limit is far above the slowest word of the block plus the longest
    // receiver stall, so only a real hang trips it.
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int FB = 16;
    localparam logic [63:0] ONE_Q = 64'd1 << FB;

    logic aclk;
    logic aresetn;
    logic s_valid;
    logic s_ready;
    qjt_pkg::in_word_t s_data;
    logic m_valid;
    logic m_ready;
    qjt_pkg::out_word_t m_data;
    logic cfg_we;
    logic [1:0] cfg_index;
    logic [31:0] cfg_data;

    quintic_joint_trajectory DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Our own copy of the block's configuration and move state.
    logic [31:0] speed_lim, extra_time, tick_step;
    logic rel_mode;
    logic signed [31:0] from_pose [3];
    logic signed [31:0] to_pose [3];
    logic [31:0] t_now, t_total;
    logic moving;

    // Positions expected on the result channel, oldest first.
    qjt_pkg::out_word_t pending_pos [$];
    int errors;
    int idle_cycles;
    int send_idle_pct, recv_stall_pct;
    bit hold_off;
    int hold_cycles;

    // One row of the directed table: the word, whether the result is typed in, and that result.
    typedef struct {
        qjt_pkg::in_word_t w;
        bit fixed;
        qjt_pkg::out_word_t res;
    } stim_row_t;
    stim_row_t dir_rows [$];

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
        errors++;
    endtask

    function automatic logic signed [31:0] clamp32(input logic signed [33:0] v);
        if (v > 34'sd2147483647) return 32'sh7fffffff;
        if (v < -34'sd2147483648) return 32'sh80000000;
        return v[31:0];
    endfunction

    // Blend factor r = 10s^3 - 15s^4 + 6s^5 from the elapsed fraction, clamped to [0, 1].
    function automatic logic [63:0] blend_factor();
        logic signed [63:0] s, p2, p3, p4, p5, r;
        if (t_total == 0 || t_now >= t_total) s = ONE_Q;
        else s = ({32'd0, t_now} << FB) / {32'd0, t_total};
        p2 = (s * s) >>> FB;
        p3 = (p2 * s) >>> FB;
        p4 = (p3 * s) >>> FB;
        p5 = (p4 * s) >>> FB;
        r = 10 * p3 - 15 * p4 + 6 * p5;
        if (r < 0) r = 0;
        if (r > $signed(ONE_Q)) r = ONE_Q;
        return r;
    endfunction

    function automatic logic signed [31:0] lerp_joint(input logic signed [31:0] a,
                                                      input logic signed [31:0] b,
                                                      input logic [63:0] r);
        logic signed [63:0] d, q;
        logic [63:0] m;
        d = 64'(b) - 64'(a);
        m = (d < 0) ? -d : d;
        q = (m * r) >> FB;
        if (d < 0) q = -q;
        return 32'(64'(a) + q);
    endfunction

    // Advances the predicted state by one word and returns the expected result.
    function automatic qjt_pkg::out_word_t trajectory_step(input qjt_pkg::in_word_t w);
        qjt_pkg::out_word_t o;
        logic signed [31:0] st [3];
        logic signed [31:0] tg [3];
        logic [63:0] best, t, mag, spd, r, ne;
        logic signed [63:0] d;
        st[0] = w.start_joint0; st[1] = w.start_joint1; st[2] = w.start_joint2;
        tg[0] = w.target_joint0; tg[1] = w.target_joint1; tg[2] = w.target_joint2;
        o = '0;
        if (w.kind == 1'b0) begin
            best = 0;
            spd = (speed_lim == 0) ? 64'd1 : {32'd0, speed_lim};
            for (int j = 0; j < 3; j++) begin
                from_pose[j] = st[j];
                to_pose[j] = rel_mode ? clamp32(34'(st[j]) + 34'(tg[j])) : tg[j];
                d = 64'(to_pose[j]) - 64'(st[j]);
                mag = (d < 0) ? -d : d;
                t = ((mag << FB) / spd) + {32'd0, extra_time};
                if (t > 64'hffffffff) t = 64'hffffffff;
                if (t > best) best = t;
            end
            t_total = best[31:0];
            t_now = 0;
            moving = 1'b1;
            o.pos_joint0 = st[0]; o.pos_joint1 = st[1]; o.pos_joint2 = st[2];
            o.phase = qjt_pkg::PHASE_STARTED;
        end else if (!moving) begin
            o.pos_joint0 = to_pose[0]; o.pos_joint1 = to_pose[1]; o.pos_joint2 = to_pose[2];
            o.phase = qjt_pkg::PHASE_IDLE;
        end else begin
            if (t_now <= t_total) begin
                r = blend_factor();
                o.pos_joint0 = lerp_joint(from_pose[0], to_pose[0], r);
                o.pos_joint1 = lerp_joint(from_pose[1], to_pose[1], r);
                o.pos_joint2 = lerp_joint(from_pose[2], to_pose[2], r);
                o.phase = qjt_pkg::PHASE_MOVING;
            end else begin
                o.pos_joint0 = to_pose[0]; o.pos_joint1 = to_pose[1];
                o.pos_joint2 = to_pose[2];
                o.phase = qjt_pkg::PHASE_ARRIVED;
            end
            ne = {32'd0, t_now} + {32'd0, tick_step};
            t_now = (ne > 64'hffffffff) ? 32'hffffffff : ne[31:0];
        end
        o.move_time = t_total;
        return o;
    endfunction

    // Result checker and watchdog. Every accepted result is compared with the oldest
    // expectation, field by field.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (pending_pos.size() == 0) begin
                    report_mismatch("unexpected word", m_data.move_time, 0);
                end else begin
                    qjt_pkg::out_word_t e;
                    e = pending_pos.pop_front();
                    if (m_data.pos_joint0 !== e.pos_joint0)
                        report_mismatch("pos_joint0", m_data.pos_joint0, e.pos_joint0);
                    if (m_data.pos_joint1 !== e.pos_joint1)
                        report_mismatch("pos_joint1", m_data.pos_joint1, e.pos_joint1);
                    if (m_data.pos_joint2 !== e.pos_joint2)
                        report_mismatch("pos_joint2", m_data.pos_joint2, e.pos_joint2);
                    if (m_data.phase !== e.phase)
                        report_mismatch("phase", m_data.phase, e.phase);
                    if (m_data.move_time !== e.move_time)
                        report_mismatch("move_time", m_data.move_time, e.move_time);
                end
            end
            if ((s_valid && s_ready) || (m_valid && m_ready)) idle_cycles <= 0;
            else idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("watchdog expired with %0d words pending", pending_pos.size());
                $display("[quintic_joint_trajectory] ERROR");
                $finish;
            end
        end
    end

    // Receiver: random stalls at the current rate, or a long hold-off when requested.
    initial begin
        m_ready = 1'b0;
        hold_cycles = 0;
        forever begin
            @(posedge aclk);
            if (hold_off) begin
                m_ready <= 1'b0;
                hold_cycles++;
                if (hold_cycles >= 400) begin
                    hold_off = 1'b0;
                    hold_cycles = 0;
                end
            end else begin
                m_ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    // Sends one word: waits out random sender gaps, then holds valid until accepted.
    // The prediction is taken at acceptance, against the state as it stands then.
    // Valid stays high after acceptance until the next word or a drain replaces it.
    task automatic send_word(input qjt_pkg::in_word_t w, input bit fixed,
                             input qjt_pkg::out_word_t res);
        qjt_pkg::out_word_t e;
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= w;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        e = trajectory_step(w);
        if (fixed && e !== res)
            report_mismatch("predictor vs table", e.move_time, res.move_time);
        pending_pos.push_back(fixed ? res : e);
    endtask

    // Waits until every expected word has come, then lets the block settle.
    task automatic drain();
        s_valid <= 1'b0;
        while (pending_pos.size() != 0) @(posedge aclk);
        repeat (80) @(posedge aclk);
    endtask

    // Register writes happen only while the block is idle.
    task automatic write_reg(input qjt_pkg::cfg_index_t idx, input logic [31:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge aclk);
        cfg_we <= 1'b0;
        @(posedge aclk);
        case (idx)
            qjt_pkg::CFG_MAX_SPEED:    speed_lim = val;
            qjt_pkg::CFG_MIN_DURATION: extra_time = val;
            qjt_pkg::CFG_SAMPLE_TIME:  tick_step = val;
            default:                   rel_mode = val[0];
        endcase
    endtask

    function automatic qjt_pkg::in_word_t make_word(input logic kind, input logic [31:0] a0,
                                                    input logic [31:0] a1,
                                                    input logic [31:0] a2,
                                                    input logic [31:0] b0,
                                                    input logic [31:0] b1,
                                                    input logic [31:0] b2);
        qjt_pkg::in_word_t w;
        w.kind = kind;
        w.start_joint0 = a0; w.start_joint1 = a1; w.start_joint2 = a2;
        w.target_joint0 = b0; w.target_joint1 = b1; w.target_joint2 = b2;
        return w;
    endfunction

    // Joint values mostly of moderate size so that moves end in a sensible number of
    // ticks, with occasional full-range values.
    function automatic logic [31:0] rand_pos();
        case ($urandom_range(9))
            0: return $urandom();
            1: return $urandom_range(1) ? 32'h7fffffff : 32'h80000000;
            default: return 32'($signed($urandom_range(2000000)) - 1000000);
        endcase
    endfunction

    function automatic qjt_pkg::in_word_t rand_start();
        return make_word(1'b0, rand_pos(), rand_pos(), rand_pos(),
                         rand_pos(), rand_pos(), rand_pos());
    endfunction

    // A tick carries noise in the unused position fields; the block must ignore it.
    function automatic qjt_pkg::in_word_t rand_tick();
        return make_word(1'b1, $urandom(), $urandom(), $urandom(),
                         $urandom(), $urandom(), $urandom());
    endfunction

    // One random phase: mostly full moves (a start and enough ticks to arrive), with
    // stray ticks and moves cut short by a new start mixed in.
    task automatic random_phase(input int n_words);
        int sent;
        int ticks;
        qjt_pkg::out_word_t dummy;
        dummy = '0;
        sent = 0;
        while (sent < n_words) begin
            if ($urandom_range(9) == 0) begin
                send_word(rand_tick(), 1'b0, dummy);
                sent++;
            end else begin
                send_word(rand_start(), 1'b0, dummy);
                sent++;
                ticks = (tick_step == 0) ? 4 : 32'(t_total / tick_step);
                if (ticks > 30) ticks = $urandom_range(30, 4);
                ticks = ticks + $urandom_range(3);
                if ($urandom_range(7) == 0) ticks = $urandom_range(ticks);
                repeat (ticks) begin
                    send_word(rand_tick(), 1'b0, dummy);
                    sent++;
                end
            end
        end
    endtask

    qjt_pkg::out_word_t r0;
    qjt_pkg::in_word_t w0;

    initial begin
        errors = 0;
        idle_cycles = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_off = 1'b0;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data = '0;
        cfg_we = 1'b0;
        cfg_index = qjt_pkg::CFG_MAX_SPEED;
        cfg_data = '0;
        speed_lim = 32'd65536;
        extra_time = 32'd131072;
        tick_step = 32'd13107;
        rel_mode = 1'b0;
        for (int j = 0; j < 3; j++) begin
            from_pose[j] = 0;
            to_pose[j] = 0;
        end
        t_now = 0;
        t_total = 0;
        moving = 1'b0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed table. A tick right after reset gives zeros in phase idle; a start
        // with start equal to goal gives move_time = min_duration; the first tick of that
        // move reports phase moving at the start position.
        r0 = '0;
        r0.phase = qjt_pkg::PHASE_IDLE;
        dir_rows.push_back('{make_word(1, '1, '1, '1, '1, '1, '1), 1'b1, r0});
        r0.phase = qjt_pkg::PHASE_STARTED;
        r0.move_time = 32'd131072;
        dir_rows.push_back('{make_word(0, 0, 0, 0, 0, 0, 0), 1'b1, r0});
        r0.phase = qjt_pkg::PHASE_MOVING;
        dir_rows.push_back('{make_word(1, 0, 0, 0, 0, 0, 0), 1'b1, r0});
        dir_rows.push_back('{make_word(0, 32'h7fffffff, 32'h80000000, 0,
                                       32'h80000000, 32'h7fffffff, 32'h00010000), 0, r0});
        for (int k = 0; k < 6; k++)
            dir_rows.push_back('{make_word(1, 0, 0, 0, 0, 0, 0), 0, r0});
        dir_rows.push_back('{make_word(0, 32'h00010000, 32'hffff0000, 32'h00000001,
                                       32'h00030000, 32'hfffd0000, 32'h00000005), 0, r0});
        for (int k = 0; k < 14; k++)
            dir_rows.push_back('{make_word(1, 0, 0, 0, 0, 0, 0), 0, r0});
        foreach (dir_rows[i]) send_word(dir_rows[i].w, dir_rows[i].fixed, dir_rows[i].res);
        drain();

        // Zero duration: no extra time and start equal to goal, so the first tick is
        // already at the goal and the next ones report arrival.
        write_reg(qjt_pkg::CFG_MIN_DURATION, 32'd0);
        write_reg(qjt_pkg::CFG_MAX_SPEED, 32'd0);
        w0 = make_word(0, 32'h12345678, 32'h80000000, 32'h7fffffff,
                       32'h12345678, 32'h80000000, 32'h7fffffff);
        send_word(w0, 1'b0, r0);
        repeat (3) send_word(rand_tick(), 1'b0, r0);
        drain();
        // Relative mode with sums that overflow both ways, at the smallest speed.
        write_reg(qjt_pkg::CFG_RELATIVE, 32'd1);
        write_reg(qjt_pkg::CFG_SAMPLE_TIME, 32'hffffffff);
        w0 = make_word(0, 32'h7fff0000, 32'h80010000, 32'h00000000,
                       32'h7fffffff, 32'h80000000, 32'h00000100);
        send_word(w0, 1'b0, r0);
        repeat (4) send_word(rand_tick(), 1'b0, r0);
        drain();

        // Random phases across several settings and idling mixes.
        for (int ph = 0; ph < 8; ph++) begin
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 66; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 66; end
                default: begin send_idle_pct = 28; recv_stall_pct = 28; end
            endcase
            case (ph)
                0: begin
                    write_reg(qjt_pkg::CFG_MAX_SPEED, 32'd65536);
                    write_reg(qjt_pkg::CFG_MIN_DURATION, 32'd131072);
                    write_reg(qjt_pkg::CFG_SAMPLE_TIME, 32'd13107);
                    write_reg(qjt_pkg::CFG_RELATIVE, 32'd0);
                end
                1: begin
                    write_reg(qjt_pkg::CFG_MAX_SPEED, 32'hffffffff);
                    write_reg(qjt_pkg::CFG_MIN_DURATION, 32'd65536);
                    write_reg(qjt_pkg::CFG_SAMPLE_TIME, 32'd1);
                    write_reg(qjt_pkg::CFG_RELATIVE, 32'd1);
                end
                2: begin
                    write_reg(qjt_pkg::CFG_MAX_SPEED, 32'd1);
                    write_reg(qjt_pkg::CFG_MIN_DURATION, 32'hffffffff);
                    write_reg(qjt_pkg::CFG_SAMPLE_TIME, 32'h40000000);
                end
                3: begin
                    write_reg(qjt_pkg::CFG_MAX_SPEED, 32'd200000);
                    write_reg(qjt_pkg::CFG_MIN_DURATION, 32'd0);
                    write_reg(qjt_pkg::CFG_SAMPLE_TIME, 32'd30000);
                    write_reg(qjt_pkg::CFG_RELATIVE, 32'd0);
                end
                default: begin
                    write_reg(qjt_pkg::CFG_MAX_SPEED, $urandom_range(1000000, 1));
                    write_reg(qjt_pkg::CFG_MIN_DURATION, $urandom_range(200000));
                    write_reg(qjt_pkg::CFG_SAMPLE_TIME, $urandom_range(100000, 1));
                    write_reg(qjt_pkg::CFG_RELATIVE, $urandom_range(1));
                end
            endcase
            // Long receiver hold-off while the sender keeps offering words.
            if (ph == 2) hold_off = 1'b1;
            random_phase(200);
            // Sender pause until every expected word has come.
            drain();
        end

        drain();
        if (errors == 0) begin
            $display("[quintic_joint_trajectory] OK");
        end else begin
            $display("[quintic_joint_trajectory] ERROR");
        end
        $finish;
    end
endmodule
